// ===== rtl/mtkd_pkg.sv =====
// mtkd_pkg: constants, codes, layout rom and shared types of the multi-tap keypad decoder
// no dependencies; imported by every module of the block

package mtkd_pkg;

   localparam int DIGIT_KEYS   = 10;
   localparam int TAPS_PER_KEY = 5;
   localparam int ROM_ROWS     = 10;
   localparam int ROM_COLS     = 5;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] TIMEOUT_RESET = 8'd2;

   localparam logic [4:0] KEY_DIGIT_MAX  = 5'd9;
   localparam logic [4:0] KEY_SHIFT      = 5'd10;
   localparam logic [4:0] KEY_CTRL       = 5'd11;
   localparam logic [4:0] KEY_BACKSPACE  = 5'd12;
   localparam logic [4:0] KEY_SPACE      = 5'd13;
   localparam logic [4:0] KEY_ENTER      = 5'd14;
   localparam logic [4:0] KEY_PREDICTIVE = 5'd15;
   localparam logic [4:0] KEY_TAB        = 5'd16;

   localparam logic [15:0] SYM_BACKSPACE    = 16'hFF08;
   localparam logic [15:0] SYM_SPACE        = 16'h0020;
   localparam logic [15:0] SYM_KP_ENTER     = 16'hFF8D;
   localparam logic [15:0] SYM_TAB          = 16'hFF09;
   localparam logic [15:0] SYM_LEVEL5_SHIFT = 16'hFE11;
   localparam logic [15:0] SYM_RIGHT_CTRL   = 16'hFFE4;
   localparam logic [15:0] SYM_PERIOD       = 16'h002E;
   localparam logic [15:0] SYM_A            = 16'h0061;

   typedef enum logic [1:0] {
      KIND_KEYSTROKE = 2'd0,
      KIND_DIGIT     = 2'd1,
      KIND_STATUS    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MOD_NONE  = 2'd0,
      MOD_SHIFT = 2'd1,
      MOD_CTRL  = 2'd2
   } modifier_type;

   localparam logic [15:0] LAYOUT_ROM [ROM_ROWS][ROM_COLS] = '{
      '{SYM_PERIOD,      16'h002C,        16'h002D,        16'h0027,        16'h0031},
      '{SYM_A,           SYM_A + 16'd1,   SYM_A + 16'd2,   16'h00E0,        16'h0032},
      '{SYM_A + 16'd3,   SYM_A + 16'd4,   SYM_A + 16'd5,   16'h00E8,        16'h0033},
      '{SYM_A + 16'd6,   SYM_A + 16'd7,   SYM_A + 16'd8,   16'h00EC,        16'h0034},
      '{SYM_A + 16'd9,   SYM_A + 16'd10,  SYM_A + 16'd11,  16'h005C,        16'h0035},
      '{SYM_A + 16'd12,  SYM_A + 16'd13,  SYM_A + 16'd14,  16'h00F2,        16'h0036},
      '{SYM_A + 16'd15,  SYM_A + 16'd16,  SYM_A + 16'd17,  SYM_A + 16'd18,  16'h0037},
      '{SYM_A + 16'd19,  SYM_A + 16'd20,  SYM_A + 16'd21,  16'h00F9,        16'h0038},
      '{SYM_A + 16'd22,  SYM_A + 16'd23,  SYM_A + 16'd24,  SYM_A + 16'd25,  16'h0039},
      '{16'h002B,        16'h003C,        16'h0060,        16'h00F7,        16'h0030}
   };

   // one decoded press: a single result, or backspace followed by keysym
   typedef struct packed {
      logic         two;
      kind_type     kind;
      logic [15:0]  keysym;
      modifier_type modifier_sel;
      logic [3:0]   digit_value;
      logic         predictive_on;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] rom_read(input logic [3:0] row, input logic [2:0] col);
      logic [15:0] sym;
      sym = '0;
      if (32'(row) < ROM_ROWS && 32'(col) < ROM_COLS) begin
         sym = LAYOUT_ROM[row][col];
      end
      return sym;
   endfunction

endpackage

// ===== rtl/mtkd_if.sv =====
// mtkd_req_if / mtkd_rsp_if: valid-ready channels of the keypad decoder
// no dependencies

interface mtkd_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  key_id;
   logic [31:0] now_seconds;

   modport source (output valid, output key_id, output now_seconds, input ready);
   modport sink   (input valid, input key_id, input now_seconds, output ready);
endinterface

interface mtkd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] keysym;
   logic [1:0]  modifier_sel;
   logic [3:0]  digit_value;
   logic        predictive_on;
   logic        last;

   modport source (output valid, output kind, output keysym, output modifier_sel,
                   output digit_value, output predictive_on, output last, input ready);
   modport sink   (input valid, input kind, input keysym, input modifier_sel,
                   input digit_value, input predictive_on, input last, output ready);
endinterface

// ===== rtl/multitap_keypad_decoder_unit.sv =====
// multitap_keypad_decoder_unit: top level of the multi-tap keypad decoder
// first result of a request is registered in a queue entry, then in the back end output register
// throughput: one request per cycle for single-result presses while the output is ready and the queue
// is not full; a repeat press sends two results through the single output register, one result per cycle
// reset: synchronous; clears tap, modifier and mode state, sets the timeout to 2, empties queue
// depends on mtkd_pkg, mtkd_if, mtkd_front, mtkd_queue, mtkd_back

module multitap_keypad_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   mtkd_req_if.sink   req_chan,
   mtkd_rsp_if.source rsp_chan,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import mtkd_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          pop_cmd;
   logic             push;
   logic             pop;

   mtkd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   mtkd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   mtkd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_cmd  (pop_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/mtkd_front.sv =====
// mtkd_front: accepts key requests, holds tap and mode state, pushes decoded commands
// depends on mtkd_pkg and mtkd_req_if

module mtkd_front (
   input  logic                      clock,
   input  logic                      reset,
   mtkd_req_if.sink                  req_chan,
   input  logic                      csr_we,
   input  logic [7:0]                csr_wdata,
   input  mtkd_pkg::queue_status_type q_status,
   output logic                      push,
   output mtkd_pkg::cmd_type         push_cmd
);
   import mtkd_pkg::*;

   logic [7:0]   timeout_ff, timeout_in;
   logic [3:0]   prev_key_ff, prev_key_in;
   logic         seq_active_ff, seq_active_in;
   logic [2:0]   tap_ff, tap_in;
   logic [31:0]  prev_time_ff, prev_time_in;
   modifier_type modifier_ff, modifier_in;
   logic         pred_ff, pred_in;

   logic         accept;
   logic [4:0]   key;
   logic [3:0]   row;
   logic [31:0]  elapsed;
   logic         in_time;

   assign req_chan.ready = !q_status.full;
   assign accept  = req_chan.valid && !q_status.full;
   assign key     = req_chan.key_id;
   assign elapsed = req_chan.now_seconds - prev_time_ff;
   assign in_time = elapsed < 32'(timeout_ff);
   assign row     = (key == 5'd0) ? 4'(DIGIT_KEYS - 1) : 4'(key - 5'd1);

   always_comb begin
      timeout_in    = csr_we ? csr_wdata : timeout_ff;
      prev_key_in   = prev_key_ff;
      seq_active_in = seq_active_ff;
      tap_in        = tap_ff;
      prev_time_in  = prev_time_ff;
      modifier_in   = modifier_ff;
      pred_in       = pred_ff;
      push          = 1'b0;
      push_cmd      = '0;
      push_cmd.kind = KIND_KEYSTROKE;

      if (accept) begin
         if (key <= KEY_DIGIT_MAX) begin
            if (32'(key) < DIGIT_KEYS) begin
               push = 1'b1;
               if (pred_ff) begin
                  push_cmd.kind        = KIND_DIGIT;
                  push_cmd.digit_value = key[3:0];
               end else if (seq_active_ff && prev_key_ff == key[3:0] && in_time) begin
                  push_cmd.two    = 1'b1;
                  push_cmd.keysym = rom_read(row, tap_ff);
                  tap_in          = (32'(tap_ff) < TAPS_PER_KEY - 1) ? tap_ff + 3'd1 : 3'd0;
                  prev_time_in    = req_chan.now_seconds;
               end else begin
                  push_cmd.keysym = rom_read(row, 3'd0);
                  tap_in          = 3'(1 % TAPS_PER_KEY);
                  seq_active_in   = 1'b1;
                  prev_key_in     = key[3:0];
                  prev_time_in    = req_chan.now_seconds;
               end
            end
         end else begin
            push          = 1'b1;
            seq_active_in = 1'b0;
            tap_in        = 3'd0;
            prev_key_in   = 4'd0;
            unique case (key)
               KEY_SHIFT: begin
                  modifier_in   = (modifier_ff == MOD_SHIFT) ? MOD_NONE : MOD_SHIFT;
                  push_cmd.kind = KIND_STATUS;
               end
               KEY_CTRL: begin
                  modifier_in   = (modifier_ff == MOD_CTRL) ? MOD_NONE : MOD_CTRL;
                  push_cmd.kind = KIND_STATUS;
               end
               KEY_BACKSPACE:  push_cmd.keysym = SYM_BACKSPACE;
               KEY_SPACE:      push_cmd.keysym = SYM_SPACE;
               KEY_ENTER:      push_cmd.keysym = SYM_KP_ENTER;
               KEY_TAB:        push_cmd.keysym = SYM_TAB;
               KEY_PREDICTIVE: begin
                  pred_in       = !pred_ff;
                  push_cmd.kind = KIND_STATUS;
               end
               default: begin
                  // unknown key: no result, no state change
                  push          = 1'b0;
                  seq_active_in = seq_active_ff;
                  tap_in        = tap_ff;
                  prev_key_in   = prev_key_ff;
               end
            endcase
         end
      end

      push_cmd.modifier_sel  = modifier_in;
      push_cmd.predictive_on = pred_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         prev_key_ff   <= '0;
         seq_active_ff <= 1'b0;
         tap_ff        <= '0;
         prev_time_ff  <= '0;
         modifier_ff   <= MOD_NONE;
         pred_ff       <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         prev_key_ff   <= prev_key_in;
         seq_active_ff <= seq_active_in;
         tap_ff        <= tap_in;
         prev_time_ff  <= prev_time_in;
         modifier_ff   <= modifier_in;
         pred_ff       <= pred_in;
      end
   end

endmodule

// ===== rtl/mtkd_queue.sv =====
// mtkd_queue: short command queue between the front and the back
// depends on mtkd_pkg

module mtkd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mtkd_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output mtkd_pkg::cmd_type          pop_cmd,
   output mtkd_pkg::queue_status_type q_status
);
   import mtkd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/mtkd_back.sv =====
// mtkd_back: expands queued commands into result items behind an output register
// depends on mtkd_pkg and mtkd_rsp_if

module mtkd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mtkd_pkg::cmd_type          pop_cmd,
   input  mtkd_pkg::queue_status_type q_status,
   output logic                       pop,
   mtkd_rsp_if.source                 rsp_chan
);
   import mtkd_pkg::*;

   logic        valid_ff, valid_in;
   logic        pending_ff, pending_in;
   cmd_type     hold_ff, hold_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] keysym_ff, keysym_in;
   logic [1:0]  modifier_ff, modifier_in;
   logic [3:0]  digit_ff, digit_in;
   logic        pred_ff, pred_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !valid_ff || rsp_chan.ready;
   assign pop  = load && !pending_ff && !q_status.empty;

   always_comb begin
      valid_in    = valid_ff;
      pending_in  = pending_ff;
      hold_in     = hold_ff;
      kind_in     = kind_ff;
      keysym_in   = keysym_ff;
      modifier_in = modifier_ff;
      digit_in    = digit_ff;
      pred_in     = pred_ff;
      last_in     = last_ff;
      if (load) begin
         if (pending_ff) begin
            // second result of a repeat press: the keysym after the backspace
            valid_in    = 1'b1;
            pending_in  = 1'b0;
            kind_in     = hold_ff.kind;
            keysym_in   = hold_ff.keysym;
            modifier_in = hold_ff.modifier_sel;
            digit_in    = hold_ff.digit_value;
            pred_in     = hold_ff.predictive_on;
            last_in     = 1'b1;
         end else if (!q_status.empty) begin
            valid_in    = 1'b1;
            hold_in     = pop_cmd;
            pending_in  = pop_cmd.two;
            modifier_in = pop_cmd.modifier_sel;
            pred_in     = pop_cmd.predictive_on;
            if (pop_cmd.two) begin
               kind_in   = KIND_KEYSTROKE;
               keysym_in = SYM_BACKSPACE;
               digit_in  = 4'd0;
               last_in   = 1'b0;
            end else begin
               kind_in   = pop_cmd.kind;
               keysym_in = pop_cmd.keysym;
               digit_in  = pop_cmd.digit_value;
               last_in   = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
      end
      hold_ff     <= hold_in;
      kind_ff     <= kind_in;
      keysym_ff   <= keysym_in;
      modifier_ff <= modifier_in;
      digit_ff    <= digit_in;
      pred_ff     <= pred_in;
      last_ff     <= last_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.kind          = kind_ff;
   assign rsp_chan.keysym        = keysym_ff;
   assign rsp_chan.modifier_sel  = modifier_ff;
   assign rsp_chan.digit_value   = digit_ff;
   assign rsp_chan.predictive_on = pred_ff;
   assign rsp_chan.last          = last_ff;

endmodule

// ===== rtl/mtkd_checker.sv =====
// mtkd_checker: port-level assertions of the keypad decoder, bound to the top level
// depends on mtkd_pkg and multitap_keypad_decoder_unit

module mtkd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_keysym,
   input logic [1:0]  rsp_modifier_sel,
   input logic [3:0]  rsp_digit_value,
   input logic        rsp_predictive_on,
   input logic        rsp_last
);
   import mtkd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_keysym)
         && $stable(rsp_modifier_sel) && $stable(rsp_digit_value)
         && $stable(rsp_predictive_on) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_sym_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_KEYSTROKE |-> rsp_keysym == 16'd0)
      else $error("keysym set on a non-keystroke result");

   a_first_is_bksp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_KEYSTROKE && rsp_keysym == SYM_BACKSPACE)
      else $error("non-final result is not a backspace");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second result of a repeat press did not follow");

   a_digit_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DIGIT |-> rsp_predictive_on)
      else $error("digit forwarded outside predictive mode");

endmodule

bind multitap_keypad_decoder_unit mtkd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_keysym        (rsp_chan.keysym),
   .rsp_modifier_sel  (rsp_chan.modifier_sel),
   .rsp_digit_value   (rsp_chan.digit_value),
   .rsp_predictive_on (rsp_chan.predictive_on),
   .rsp_last          (rsp_chan.last)
);

// ===== test/mtkd_result_checker.sv =====
// mtkd_result_checker: predicts the keypad decoder results from the accepted requests
// and compares each accepted result with the oldest prediction; counts failures
// depends on mtkd_pkg (codes, keysyms, layout table)

module mtkd_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [4:0]  req_key_id,
   input  logic [31:0] req_now_seconds,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [15:0] rsp_keysym,
   input  logic [1:0]  rsp_modifier_sel,
   input  logic [3:0]  rsp_digit_value,
   input  logic        rsp_predictive_on,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output int          error_count,
   output int          pending
);
   import mtkd_pkg::*;

   typedef struct packed {
      kind_type     kind;
      logic [15:0]  keysym;
      modifier_type modifier_sel;
      logic [3:0]   digit_value;
      logic         predictive_on;
      logic         last;
   } keypad_result_type;

   keypad_result_type expected_results[$];

   logic [7:0]   repeat_window;
   logic [3:0]   tapped_digit;
   logic         tapping;
   logic [2:0]   next_tap;
   logic [31:0]  last_press_time;
   modifier_type held_modifier;
   logic         predict_mode;

   function automatic logic [15:0] layout_keysym(input logic [3:0] row, input logic [2:0] col);
      if (int'(row) >= ROM_ROWS || int'(col) >= ROM_COLS) begin
         return 16'h0000;
      end
      return LAYOUT_ROM[row][col];
   endfunction

   function automatic void queue_result(input kind_type kind, input logic [15:0] sym,
                                        input logic [3:0] digit, input logic last);
      keypad_result_type r;
      r.kind          = kind;
      r.keysym        = sym;
      r.modifier_sel  = held_modifier;
      r.digit_value   = digit;
      r.predictive_on = predict_mode;
      r.last          = last;
      expected_results.push_back(r);
   endfunction

   function automatic void end_taps();
      tapping      = 1'b0;
      next_tap     = 3'd0;
      tapped_digit = 4'd0;
   endfunction

   function automatic void decode_press(input logic [4:0] key, input logic [31:0] stamp);
      logic [3:0]  row;
      logic [31:0] elapsed;
      elapsed = stamp - last_press_time;
      if (key <= KEY_DIGIT_MAX) begin
         if (predict_mode) begin
            queue_result(KIND_DIGIT, 16'h0000, key[3:0], 1'b1);
         end else begin
            row = (key == 5'd0) ? 4'(DIGIT_KEYS - 1) : key[3:0] - 4'd1;
            if (tapping && tapped_digit == key[3:0] && elapsed < {24'd0, repeat_window}) begin
               queue_result(KIND_KEYSTROKE, SYM_BACKSPACE, 4'd0, 1'b0);
               queue_result(KIND_KEYSTROKE, layout_keysym(row, next_tap), 4'd0, 1'b1);
               next_tap = (int'(next_tap) < TAPS_PER_KEY - 1) ? next_tap + 3'd1 : 3'd0;
            end else begin
               queue_result(KIND_KEYSTROKE, layout_keysym(row, 3'd0), 4'd0, 1'b1);
               next_tap     = 3'(1 % TAPS_PER_KEY);
               tapping      = 1'b1;
               tapped_digit = key[3:0];
            end
            last_press_time = stamp;
         end
      end else begin
         case (key)
            KEY_SHIFT: begin
               held_modifier = (held_modifier == MOD_SHIFT) ? MOD_NONE : MOD_SHIFT;
               end_taps();
               queue_result(KIND_STATUS, 16'h0000, 4'd0, 1'b1);
            end
            KEY_CTRL: begin
               held_modifier = (held_modifier == MOD_CTRL) ? MOD_NONE : MOD_CTRL;
               end_taps();
               queue_result(KIND_STATUS, 16'h0000, 4'd0, 1'b1);
            end
            KEY_BACKSPACE: begin
               end_taps();
               queue_result(KIND_KEYSTROKE, SYM_BACKSPACE, 4'd0, 1'b1);
            end
            KEY_SPACE: begin
               end_taps();
               queue_result(KIND_KEYSTROKE, SYM_SPACE, 4'd0, 1'b1);
            end
            KEY_ENTER: begin
               end_taps();
               queue_result(KIND_KEYSTROKE, SYM_KP_ENTER, 4'd0, 1'b1);
            end
            KEY_PREDICTIVE: begin
               predict_mode = !predict_mode;
               end_taps();
               queue_result(KIND_STATUS, 16'h0000, 4'd0, 1'b1);
            end
            KEY_TAB: begin
               end_taps();
               queue_result(KIND_KEYSTROKE, SYM_TAB, 4'd0, 1'b1);
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic void report(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] %s", $time, what);
      end
   endfunction

   function automatic void check_result();
      keypad_result_type got;
      keypad_result_type want;
      got.kind          = kind_type'(rsp_kind);
      got.keysym        = rsp_keysym;
      got.modifier_sel  = modifier_type'(rsp_modifier_sel);
      got.digit_value   = rsp_digit_value;
      got.predictive_on = rsp_predictive_on;
      got.last          = rsp_last;
      if (expected_results.size() == 0) begin
         report($sformatf({"unexpected result kind=%0d keysym=%h mod=%0d digit=%0d ",
                           "pred=%0b last=%0b"},
                          got.kind, got.keysym, got.modifier_sel, got.digit_value,
                          got.predictive_on, got.last));
      end else begin
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.keysym !== want.keysym ||
             got.modifier_sel !== want.modifier_sel || got.digit_value !== want.digit_value ||
             got.predictive_on !== want.predictive_on || got.last !== want.last) begin
            report($sformatf({"mismatch: expected kind=%0d keysym=%h mod=%0d digit=%0d pred=%0b ",
                              "last=%0b, got kind=%0d keysym=%h mod=%0d digit=%0d pred=%0b last=%0b"},
                             want.kind, want.keysym, want.modifier_sel, want.digit_value,
                             want.predictive_on, want.last, got.kind, got.keysym,
                             got.modifier_sel, got.digit_value, got.predictive_on, got.last));
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         repeat_window   = TIMEOUT_RESET;
         end_taps();
         last_press_time = 32'd0;
         held_modifier   = MOD_NONE;
         predict_mode    = 1'b0;
      end else begin
         if (csr_we) begin
            repeat_window = csr_wdata;
         end
         if (req_valid && req_ready) begin
            decode_press(req_key_id, req_now_seconds);
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
      end
      pending <= expected_results.size();
   end

endmodule

// ===== test/tb_multitap_keypad_decoder_unit.sv =====
// tb_multitap_keypad_decoder_unit: drives key press requests, timeout register writes and
// result backpressure into the keypad decoder; mtkd_result_checker does the checking
// depends on mtkd_pkg, mtkd_if, multitap_keypad_decoder_unit, mtkd_result_checker

module tb_multitap_keypad_decoder_unit;
   import mtkd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   int          error_count;
   int          pending;
   int          cycles = 0;
   int          presses_sent;
   logic        steady;
   logic [31:0] now_s;
   logic [7:0]  timeout_now;

   mtkd_req_if req_chan ();
   mtkd_rsp_if rsp_chan ();

   multitap_keypad_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   mtkd_result_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_key_id        (req_chan.key_id),
      .req_now_seconds   (req_chan.now_seconds),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_kind          (rsp_chan.kind),
      .rsp_keysym        (rsp_chan.keysym),
      .rsp_modifier_sel  (rsp_chan.modifier_sel),
      .rsp_digit_value   (rsp_chan.digit_value),
      .rsp_predictive_on (rsp_chan.predictive_on),
      .rsp_last          (rsp_chan.last),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .pending           (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // mostly short idle spells, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // time step: mostly inside the repeat window, sometimes right on its edge, else a random step up to 1000
   function automatic logic [31:0] next_step();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         return (timeout_now == 8'd0) ? 32'd0 : 32'($urandom_range(0, int'(timeout_now) - 1));
      end else if (r < 9) begin
         return {24'd0, timeout_now};
      end
      return 32'($urandom_range(0, 1000));
   endfunction

   initial begin
      int stall;
      int calm;
      stall = 0;
      calm  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm > 0) begin
            rsp_chan.ready <= 1'b1;
            calm--;
         end else if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 99) < 3) begin
               calm = $urandom_range(50, 200);
            end else if ($urandom_range(0, 99) < 25) begin
               stall = idle_length();
            end
         end
      end
   end

   task automatic press(input logic [4:0] key, input logic [31:0] stamp);
      int gap;
      gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.key_id      <= key;
      req_chan.now_seconds <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (key <= KEY_TAB) begin
         presses_sent++;
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      drain();
      csr_we      <= 1'b1;
      csr_wdata   <= value;
      timeout_now = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int         target;
      int         taps;
      int         r;
      logic [4:0] key;
      target = presses_sent + count;
      while (presses_sent < target) begin
         r = $urandom_range(0, 99);
         steady = ($urandom_range(0, 7) == 0);
         if (r < 55) begin
            key  = 5'($urandom_range(0, 9));
            taps = $urandom_range(1, 7);
            repeat (taps) begin
               now_s = now_s + next_step();
               press(key, now_s);
            end
         end else if (r < 85) begin
            key = 5'($urandom_range(0, 16));
            if (key == KEY_PREDICTIVE && $urandom_range(0, 2) != 0) begin
               key = KEY_SPACE;
            end
            now_s = now_s + next_step();
            press(key, now_s);
         end else if (r < 95) begin
            now_s = $urandom;
            press(5'($urandom_range(0, 16)), now_s);
         end else begin
            press(5'($urandom_range(17, 31)), $urandom);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = 8'd0;
      req_chan.valid       = 1'b0;
      req_chan.key_id      = 5'd0;
      req_chan.now_seconds = 32'd0;
      presses_sent         = 0;
      steady               = 1'b0;
      now_s                = 32'd0;
      timeout_now          = TIMEOUT_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // tap cycle on one key with wrap, new key, timeout then repeat
      press(5'd1, 32'd0);
      press(5'd1, 32'd1);
      press(5'd1, 32'd1);
      press(5'd1, 32'd2);
      press(5'd1, 32'd2);
      press(5'd1, 32'd3);
      press(5'd0, 32'd3);
      press(5'd0, 32'd10);
      press(5'd0, 32'd10);
      // time wrap forward and a clock running backwards
      press(KEY_DIGIT_MAX, 32'hFFFF_FFFF);
      press(KEY_DIGIT_MAX, 32'd0);
      press(KEY_DIGIT_MAX, 32'd4);
      press(KEY_DIGIT_MAX, 32'd3);
      // modifiers, edit keys, predictive mode, ignored keys
      press(KEY_SHIFT, 32'd20);
      press(5'd5, 32'd21);
      press(KEY_CTRL, 32'd22);
      press(KEY_CTRL, 32'd23);
      press(KEY_BACKSPACE, 32'd24);
      press(KEY_SPACE, 32'd25);
      press(KEY_ENTER, 32'd26);
      press(KEY_TAB, 32'd27);
      press(KEY_PREDICTIVE, 32'd28);
      press(5'd7, 32'd29);
      press(5'd0, 32'd29);
      press(KEY_PREDICTIVE, 32'd30);
      press(5'd17, 32'd31);
      press(5'd31, 32'hFFFF_FFFF);
      now_s = 32'd40;

      write_timeout(8'd255);
      random_phase(80);
      write_timeout(8'd1);
      random_phase(80);
      write_timeout(8'd0);
      random_phase(60);
      write_timeout(8'($urandom_range(3, 254)));
      random_phase(80);
      write_timeout(TIMEOUT_RESET);
      random_phase(80);
      drain();

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mtkd_pkg.sv
rtl/mtkd_if.sv
rtl/mtkd_front.sv
rtl/mtkd_queue.sv
rtl/mtkd_back.sv
rtl/multitap_keypad_decoder_unit.sv
rtl/mtkd_checker.sv
test/mtkd_result_checker.sv
test/tb_multitap_keypad_decoder_unit.sv
